@@ rtl/rdc_pkg.sv @@
package rdc_pkg;

	localparam int unsigned NUM_W       = 32;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned DIG_W       = 4;
	localparam int unsigned MAX_RADIX   = 16;
	localparam int unsigned DIGIT_SLOTS = 32;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned SLOT_W      = $clog2(DIGIT_SLOTS);
	localparam int unsigned STEP_W      = $clog2(NUM_W);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LAST  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // take in a new number
		logic step;        // one restoring division step
		logic store;       // write the remainder digit and restart the division
		logic emit_sign;   // put the minus sign into the output register
		logic rd;          // read the digit store at the current index
		logic emit_digit;  // put the alphabet character of the read digit out
	} rdc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic alph_ok;
		logic div_last;
		logic quot_zero;
		logic neg;
		logic out_free;
		logic idx_zero;
	} rdc_stat_t;

	function automatic logic forbidden_char(input logic [CHAR_W-1:0] c);
		return (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_TAB) || (c == CH_LF) ||
		       (c == CH_VT) || (c == CH_FF) || (c == CH_CR) || (c == CH_SPACE) ||
		       (c == CH_NUL);
	endfunction

endpackage

@@ rtl/rdc_ctrl.sv @@
module rdc_ctrl
	import rdc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  rdc_stat_t stat,
	output rdc_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIV   = 6'b000010,
		S_STORE = 6'b000100,
		S_SIGN  = 6'b001000,
		S_RD    = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				// A word met with an unusable alphabet is taken and dropped.
				if (in_valid && stat.alph_ok) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (stat.div_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				if (!stat.quot_zero) begin
					state_d = S_DIV;
				end else if (stat.neg) begin
					state_d = S_SIGN;
				end else begin
					state_d = S_RD;
				end
			end
			S_SIGN: begin
				if (stat.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					state_d        = stat.idx_zero ? S_IDLE : S_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/rdc_dpath.sv @@
module rdc_dpath
	import rdc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [NUM_W-1:0]  number,
	output logic [CHAR_W-1:0]        character,
	output logic                     last_char,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  rdc_cmd_t                 cmd,
	output rdc_stat_t                stat
);

	logic [CNT_W-1:0]      count_q;
	logic [CFG_DATA_W-1:0] first_q;
	logic [CFG_DATA_W-1:0] last_q;

	logic [NUM_W-1:0]  quot_q;
	logic [DIG_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [SLOT_W:0]   fill_q;
	logic [SLOT_W-1:0] idx_q;
	logic [DIG_W-1:0]  rd_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_char_q;

	logic [DIG_W-1:0] store_mem [DIGIT_SLOTS];

	logic [CHAR_W-1:0] alph [MAX_RADIX];
	logic [MAX_RADIX-1:0] in_use;
	logic               bad;
	logic [NUM_W-1:0]   mag;
	logic [DIG_W:0]     rem_sh;
	logic [DIG_W:0]     rem_sub;
	logic               take;
	logic               out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			last_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIGIT_COUNT:  count_q <= cfg_data[CNT_W-1:0];
				CFG_DIGITS_FIRST: first_q <= cfg_data;
				CFG_DIGITS_LAST:  last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Alphabet check: radix two to sixteen, each character in use allowed and unique.
	always_comb begin
		bad = (count_q < CNT_W'(2)) || (count_q > CNT_W'(MAX_RADIX));
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (i < 8) begin
				alph[i] = first_q[i*CHAR_W +: CHAR_W];
			end else begin
				alph[i] = last_q[(i-8)*CHAR_W +: CHAR_W];
			end
			in_use[i] = (CNT_W'(i) < count_q);
		end
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (in_use[i] && forbidden_char(alph[i])) begin
				bad = 1'b1;
			end
			for (int j = i + 1; j < MAX_RADIX; j++) begin
				if (in_use[j] && (alph[i] == alph[j])) begin
					bad = 1'b1;
				end
			end
		end
	end

	assign mag     = number[NUM_W-1] ? (NUM_W'(0) - unsigned'(number)) : unsigned'(number);
	assign rem_sh  = {rem_q, quot_q[NUM_W-1]};
	assign take    = (rem_sh >= count_q);
	assign rem_sub = rem_sh - count_q;

	// Division state: one quotient bit per step, remainder stays below the radix.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q <= mag;
			rem_q  <= '0;
			step_q <= '0;
			neg_q  <= number[NUM_W-1];
			fill_q <= '0;
		end else if (cmd.step) begin
			quot_q <= {quot_q[NUM_W-2:0], take};
			rem_q  <= take ? rem_sub[DIG_W-1:0] : rem_sh[DIG_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end else if (cmd.store) begin
			rem_q  <= '0;
			step_q <= '0;
			fill_q <= fill_q + (SLOT_W+1)'(1);
			idx_q  <= fill_q[SLOT_W-1:0];
		end else if (cmd.emit_digit) begin
			idx_q  <= idx_q - SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_mem[fill_q[SLOT_W-1:0]] <= rem_q;
		end
		if (cmd.rd) begin
			rd_q <= store_mem[idx_q];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q      <= CH_MINUS;
			last_char_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q      <= alph[rd_q];
			last_char_q <= (idx_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_char_q;

	assign stat.alph_ok   = !bad;
	assign stat.div_last  = (step_q == STEP_W'(NUM_W - 1));
	assign stat.quot_zero = (quot_q == '0);
	assign stat.neg       = neg_q;
	assign stat.out_free  = out_free;
	assign stat.idx_zero  = (idx_q == '0);

endmodule

@@ rtl/radix_digit_converter_unit.sv @@
// Integer to radix text converter.
// The input channel (in_valid, in_stall, number) takes one signed 32-bit word.
// The output channel (out_valid, out_stall, character, last_char) returns its
// text one character per word, most significant digit first, led by a minus
// sign for negative numbers; last_char marks the final character. The most
// negative number prints its full magnitude.
// The radix is digit_count, and the alphabet sits in two 64-bit registers,
// character 0 in the low byte. Write them through cfg_we, cfg_index and
// cfg_data only while the block is idle. If the alphabet is shorter than two,
// longer than sixteen, holds a sign, whitespace or zero byte, or repeats a
// character, an input word is taken and produces nothing.
// Each digit passes through the bit-serial divider in 32 shift and subtract
// steps plus one store; then every character is read from the digit store and
// registered into the output register. in_stall stays high until the last
// character has been handed to the output register. A stalled receiver simply
// holds the current character and pauses the read-back. Reset empties the output
// register, returns the controller to idle and clears all three registers.
module radix_digit_converter_unit
	import rdc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [NUM_W-1:0] number,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHAR_W-1:0]       character,
	output logic                    last_char
);

	rdc_cmd_t  cmd;
	rdc_stat_t stat;

	// The controller sequences load, division, digit store and read-back.
	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, divider, digit store and output register.
	rdc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.number    (number),
		.character (character),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
